/* rtl/core/tsf_pkg.sv */
// ----------------------------------------------------------------------------
// tsf_pkg: shared types and constants of the subrecord finder
// Request and response payloads, the queue entry passed from the front end to
// the walker, register indexes and default geometry.
// ----------------------------------------------------------------------------
package tsf_pkg;

   // Default subrecord geometry.
   localparam int ID_BYTES_DEFAULT         = 4;
   localparam int SUB_HEADER_BYTES_DEFAULT = 8;

   // Depth of the queue between front end and walker.
   localparam int QUEUE_DEPTH = 2;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_WIDTH = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET_ID    = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_START_OFFSET = CSR_INDEX_WIDTH'(1);

   localparam logic [31:0] START_OFFSET_RESET = 32'd16;
   localparam logic [31:0] ALL_ONES           = 32'hFFFF_FFFF;

   // One request: a record byte and the last-byte flag.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   // One response: the search result of a record.
   typedef struct packed {
      logic        found;
      logic [31:0] match_offset;
      logic [31:0] payload_size;
   } rsp_payload_type;

   // A classified request as it sits in the queue.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       byte_nonzero;
   } entry_type;

   // Configuration values seen by the walker.
   typedef struct packed {
      logic [31:0] target_id;
      logic [31:0] start_offset;
   } config_type;

endpackage

/* rtl/core/tsf_front.sv */
// ----------------------------------------------------------------------------
// tsf_front: request intake
// Accepts request bytes, tags each with its classification and pushes it into
// the queue; stalls the requester while the queue is full.
// ----------------------------------------------------------------------------
module tsf_front
   import tsf_pkg::*;
(
   input  logic            req_valid,
   input  req_payload_type req_payload,
   output logic            req_stall,
   input  logic            queue_full,
   output logic            push,
   output entry_type       push_entry
);

   // The queue is the only thing that can hold a request back.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Classify the byte: a nonzero flag serves the long id and size checks.
   always_comb begin
      push_entry.data_byte    = req_payload.data_byte;
      push_entry.last_byte    = req_payload.last_byte;
      push_entry.byte_nonzero = (req_payload.data_byte != 8'd0);
   end

endmodule

/* rtl/core/tsf_queue.sv */
// ----------------------------------------------------------------------------
// tsf_queue: short FIFO between front end and walker
// Register based, simultaneous push and pop allowed.
// ----------------------------------------------------------------------------
module tsf_queue
   import tsf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_COUNT = CW'(QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_SLOT   = PW'(QUEUE_DEPTH - 1);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full       = (count_ff == DEPTH_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/core/tsf_walker.sv */
// ----------------------------------------------------------------------------
// tsf_walker: subrecord walk and response register
// Takes one classified byte a cycle from the queue while no response stalls,
// walks the subrecord chain, holds the response until the consumer takes it.
// ----------------------------------------------------------------------------
module tsf_walker
   import tsf_pkg::*;
#(
   parameter int ID_BYTES         = ID_BYTES_DEFAULT,
   parameter int SUB_HEADER_BYTES = SUB_HEADER_BYTES_DEFAULT
)
(
   input  logic            clock,
   input  logic            reset,
   input  config_type      cfg,
   input  logic            head_valid,
   input  entry_type       head_entry,
   output logic            pop,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload,
   input  logic            rsp_stall
);

   // At least two bits, so the byte lane select below always stays in range.
   localparam int HW = (SUB_HEADER_BYTES > 4) ? $clog2(SUB_HEADER_BYTES) : 2;

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_HEADER,
      PH_PAYLOAD,
      PH_ENDED,
      PH_REPORTED
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [31:0]     byte_count_ff, byte_count_in;
   logic [HW-1:0]   hidx_ff, hidx_in;
   logic [31:0]     cur_id_ff, cur_id_in;
   logic [31:0]     cur_size_ff, cur_size_in;
   logic [31:0]     payload_left_ff, payload_left_in;
   logic [31:0]     sub_start_ff, sub_start_in;
   logic            result_given_ff, result_given_in;
   logic            id_high_ff, id_high_in;
   logic            size_high_ff, size_high_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            step;
   logic [31:0]     pos;
   logic [31:0]     pos_next;
   logic [HW-1:0]   size_idx;
   logic [31:0]     size_final;
   logic [31:0]     left_dec;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A byte is taken only when the response register is free or being freed.
   assign step = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = step;

   assign pos      = byte_count_ff;
   assign pos_next = (pos == ALL_ONES) ? ALL_ONES : pos + 32'd1;

   // Walk one byte.
   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      hidx_in         = hidx_ff;
      cur_id_in       = cur_id_ff;
      cur_size_in     = cur_size_ff;
      payload_left_in = payload_left_ff;
      sub_start_in    = sub_start_ff;
      result_given_in = result_given_ff;
      id_high_in      = id_high_ff;
      size_high_in    = size_high_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_payload_in  = rsp_payload_ff;
      size_idx        = hidx_ff - HW'(ID_BYTES);
      size_final      = cur_size_ff;
      left_dec        = payload_left_ff - 32'd1;

      if (step) begin
         // The walk begins once the start offset is reached.
         if (phase_ff == PH_SKIP && pos >= cfg.start_offset) begin
            phase_in     = PH_HEADER;
            hidx_in      = '0;
            cur_id_in    = '0;
            cur_size_in  = '0;
            sub_start_in = pos;
            id_high_in   = 1'b0;
            size_high_in = 1'b0;
         end

         if (phase_in == PH_HEADER) begin
            size_idx = hidx_in - HW'(ID_BYTES);
            if (32'(hidx_in) < 32'(ID_BYTES)) begin
               if (32'(hidx_in) < 32'd4) begin
                  cur_id_in[8*hidx_in[1:0] +: 8] = head_entry.data_byte;
               end else if (head_entry.byte_nonzero) begin
                  id_high_in = 1'b1;
               end
            end else begin
               if (32'(size_idx) < 32'd4) begin
                  cur_size_in[8*size_idx[1:0] +: 8] = head_entry.data_byte;
               end else if (head_entry.byte_nonzero) begin
                  size_high_in = 1'b1;
               end
            end
            // Header done: a zero size ends the walk.
            if (32'(hidx_in) + 32'd1 >= 32'(SUB_HEADER_BYTES)) begin
               size_final  = size_high_in ? ALL_ONES : cur_size_in;
               cur_size_in = size_final;
               if (size_final == 32'd0) begin
                  phase_in = PH_ENDED;
               end else begin
                  payload_left_in = size_final;
                  phase_in        = PH_PAYLOAD;
               end
            end else begin
               hidx_in = hidx_in + HW'(1);
            end
         end else if (phase_ff == PH_PAYLOAD) begin
            payload_left_in = left_dec;
            if (left_dec == 32'd0) begin
               if (cur_id_ff == cfg.target_id && !id_high_ff) begin
                  rsp_valid_in                = 1'b1;
                  rsp_payload_in.found        = 1'b1;
                  rsp_payload_in.match_offset = sub_start_ff;
                  rsp_payload_in.payload_size = cur_size_ff;
                  result_given_in             = 1'b1;
                  phase_in                    = PH_REPORTED;
               end else begin
                  phase_in     = PH_HEADER;
                  hidx_in      = '0;
                  cur_id_in    = '0;
                  cur_size_in  = '0;
                  sub_start_in = pos_next;
                  id_high_in   = 1'b0;
                  size_high_in = 1'b0;
               end
            end
         end

         byte_count_in = pos_next;

         // End of record: report not found unless a match was given.
         if (head_entry.last_byte) begin
            if (!result_given_in) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.found        = 1'b0;
               rsp_payload_in.match_offset = pos_next;
               rsp_payload_in.payload_size = 32'd0;
            end
            phase_in        = PH_SKIP;
            byte_count_in   = '0;
            hidx_in         = '0;
            cur_id_in       = '0;
            cur_size_in     = '0;
            payload_left_in = '0;
            sub_start_in    = '0;
            result_given_in = 1'b0;
            id_high_in      = 1'b0;
            size_high_in    = 1'b0;
         end
      end
   end

   // Walk state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SKIP;
         byte_count_ff   <= '0;
         hidx_ff         <= '0;
         cur_id_ff       <= '0;
         cur_size_ff     <= '0;
         payload_left_ff <= '0;
         sub_start_ff    <= '0;
         result_given_ff <= 1'b0;
         id_high_ff      <= 1'b0;
         size_high_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         hidx_ff         <= hidx_in;
         cur_id_ff       <= cur_id_in;
         cur_size_ff     <= cur_size_in;
         payload_left_ff <= payload_left_in;
         sub_start_ff    <= sub_start_in;
         result_given_ff <= result_given_in;
         id_high_ff      <= id_high_in;
         size_high_ff    <= size_high_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

/* rtl/core/tlv_subrecord_finder.sv */
// ----------------------------------------------------------------------------
// tlv_subrecord_finder: TLV subrecord search over a record byte stream
// Walks id/size/payload subrecords from a configured offset and reports the
// first complete subrecord whose id matches the configured target.
//
//   port group | direction | handshake         | carries
//   req_       | in        | valid / stall     | data_byte, last_byte
//   rsp_       | out       | valid / stall     | found, match_offset, payload_size
//   csr_       | in        | valid / ready     | register index, write data
//
// One byte per cycle is sustained while no response is stalled; the walker's
// registered byte step sets that figure. A response passes the queue slot and
// then the walker's response register before it is offered.
// Reset is synchronous and clears the walk; registers return to their defaults.
// A stalled response holds the walker while the two-entry queue absorbs bytes.
// Configuration writes are always ready.
// ----------------------------------------------------------------------------
module tlv_subrecord_finder
   import tsf_pkg::*;
#(
   parameter int ID_BYTES         = ID_BYTES_DEFAULT,
   parameter int SUB_HEADER_BYTES = SUB_HEADER_BYTES_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  req_payload_type            req_payload,
   output logic                       req_stall,
   output logic                       rsp_valid,
   output rsp_payload_type            rsp_payload,
   input  logic                       rsp_stall,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_data
);

   config_type cfg_ff, cfg_in;
   logic       queue_full;
   logic       push;
   entry_type  push_entry;
   logic       pop;
   logic       head_valid;
   entry_type  head_entry;

   assign csr_ready = 1'b1;

   // Register write decode; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TARGET_ID:    cfg_in.target_id    = csr_data;
            REG_START_OFFSET: cfg_in.start_offset = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_id    <= '0;
         cfg_ff.start_offset <= START_OFFSET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsf_front u_front (
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   tsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   tsf_walker #(
      .ID_BYTES         (ID_BYTES),
      .SUB_HEADER_BYTES (SUB_HEADER_BYTES)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the TLV subrecord finder
// Sends records a byte per request, predicts each record's search result with a
// walker of its own, and compares every response with the oldest prediction.
// Directed records cover the special cases, then random records run under
// changing settings and random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
   import tsf_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_CYCLES  = 300;

   typedef enum logic [2:0] {
      WALK_SKIP, WALK_HEADER, WALK_PAYLOAD, WALK_ENDED, WALK_REPORTED
   } walk_phase_type;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   req_payload_type            req_payload = '0;
   logic                       req_stall;
   logic                       rsp_valid;
   rsp_payload_type            rsp_payload;
   logic                       rsp_stall   = 1'b0;
   logic                       csr_valid   = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index   = '0;
   logic [31:0]                csr_data    = '0;

   // Register copies and walker state of the predictor.
   logic [31:0]    cfg_target = 32'd0;
   logic [31:0]    cfg_start  = START_OFFSET_RESET;
   logic [31:0]    wk_count, wk_id, wk_size, wk_left, wk_start;
   logic [3:0]     wk_hdr_idx;
   walk_phase_type wk_phase;
   logic           wk_given, wk_id_high, wk_size_high;

   rsp_payload_type expected_results[$];
   logic [7:0]      record_bytes[$];

   int          mismatch_count = 0;
   int          results_seen   = 0;
   int          items_sent     = 0;
   int          cycle_count    = 0;
   int          send_idle_pct  = 0;
   int          recv_idle_pct  = 0;
   int unsigned hold_left      = 0;

   tlv_subrecord_finder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d results pending", cycle_count,
                  expected_results.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Response stall: a long hold when one is requested, random otherwise.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Clear the walker back to its state at the start of a record.
   task automatic clear_walk();
      wk_count     = '0;
      wk_hdr_idx   = '0;
      wk_id        = '0;
      wk_size      = '0;
      wk_left      = '0;
      wk_start     = '0;
      wk_phase     = WALK_SKIP;
      wk_given     = 1'b0;
      wk_id_high   = 1'b0;
      wk_size_high = 1'b0;
   endtask

   task automatic begin_subrecord(input logic [31:0] pos);
      wk_phase     = WALK_HEADER;
      wk_hdr_idx   = '0;
      wk_id        = '0;
      wk_size      = '0;
      wk_start     = pos;
      wk_id_high   = 1'b0;
      wk_size_high = 1'b0;
   endtask

   // Advance the walker by one record byte and queue any result it gives.
   task automatic walk_byte(input req_payload_type item);
      logic [31:0]     pos;
      logic [31:0]     hi;
      logic [31:0]     si;
      rsp_payload_type res;
      pos = wk_count;
      if (wk_phase == WALK_SKIP && pos >= cfg_start)
         begin_subrecord(pos);

      if (wk_phase == WALK_HEADER) begin
         hi = 32'(wk_hdr_idx);
         if (hi < ID_BYTES_DEFAULT) begin
            if (hi < 4)
               wk_id = wk_id | (32'(item.data_byte) << (8 * hi));
            else if (item.data_byte != 8'd0)
               wk_id_high = 1'b1;
         end else begin
            si = hi - ID_BYTES_DEFAULT;
            if (si < 4)
               wk_size = wk_size | (32'(item.data_byte) << (8 * si));
            else if (item.data_byte != 8'd0)
               wk_size_high = 1'b1;
         end
         if (hi + 1 >= SUB_HEADER_BYTES_DEFAULT) begin
            if (wk_size_high)
               wk_size = ALL_ONES;
            if (wk_size == 32'd0) begin
               wk_phase = WALK_ENDED;
            end else begin
               wk_left  = wk_size;
               wk_phase = WALK_PAYLOAD;
            end
         end else begin
            wk_hdr_idx = 4'(hi + 1);
         end
      end else if (wk_phase == WALK_PAYLOAD) begin
         wk_left = wk_left - 1;
         if (wk_left == 32'd0) begin
            if (wk_id == cfg_target && !wk_id_high) begin
               res.found        = 1'b1;
               res.match_offset = wk_start;
               res.payload_size = wk_size;
               expected_results = {expected_results, res};
               wk_given = 1'b1;
               wk_phase = WALK_REPORTED;
            end else begin
               begin_subrecord((pos == ALL_ONES) ? ALL_ONES : pos + 1);
            end
         end
      end

      if (wk_count != ALL_ONES)
         wk_count = wk_count + 1;

      // The record ends: a search with no match reports the record length.
      if (item.last_byte) begin
         if (!wk_given) begin
            res.found        = 1'b0;
            res.match_offset = wk_count;
            res.payload_size = 32'd0;
            expected_results = {expected_results, res};
         end
         clear_walk();
      end
   endtask

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("response with none expected: found=%0b off=%0d size=%0d",
                                      rsp_payload.found, rsp_payload.match_offset,
                                      rsp_payload.payload_size));
         end else begin
            want = expected_results.pop_front();
            if (rsp_payload.found !== want.found)
               report_mismatch($sformatf("found %0b, expected %0b",
                                         rsp_payload.found, want.found));
            if (rsp_payload.match_offset !== want.match_offset)
               report_mismatch($sformatf("match_offset %0d, expected %0d",
                                         rsp_payload.match_offset, want.match_offset));
            if (rsp_payload.payload_size !== want.payload_size)
               report_mismatch($sformatf("payload_size %0d, expected %0d",
                                         rsp_payload.payload_size, want.payload_size));
         end
      end
   end

   // Send one byte request, with random idle cycles ahead of it.
   task automatic send_byte(input logic [7:0] data, input logic last);
      req_payload_type item;
      item.data_byte = data;
      item.last_byte = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      walk_byte(item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_record();
      foreach (record_bytes[i])
         send_byte(record_bytes[i], i == record_bytes.size() - 1);
      record_bytes.delete();
   endtask

   task automatic push_fill(input int count);
      repeat (count)
         record_bytes = {record_bytes, 8'($urandom_range(255))};
   endtask

   // Append a subrecord header and the given number of payload bytes.
   task automatic push_sub(input logic [31:0] id, input logic [31:0] size, input int count);
      for (int i = 0; i < 4; i++)
         record_bytes = {record_bytes, id[8*i +: 8]};
      for (int i = 0; i < 4; i++)
         record_bytes = {record_bytes, size[8*i +: 8]};
      push_fill(count);
   endtask

   // Wait until every predicted result has come and the block is quiet.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES)
         @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      if (idx == REG_TARGET_ID)
         cfg_target = value;
      else if (idx == REG_START_OFFSET)
         cfg_start = value;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [31:0] target, input logic [31:0] start);
      settle_block();
      csr_write(REG_TARGET_ID, target);
      csr_write(REG_START_OFFSET, start);
   endtask

   // Reset values: target id zero, walk from offset 16.
   task automatic test_reset_defaults();
      push_fill(16);
      push_sub(32'd0, 32'd2, 2);
      send_record();
      push_fill(10);
      send_record();
      settle_block();
   endtask

   // One record per special case, walking from offset zero.
   task automatic test_directed_cases();
      logic [31:0] target;
      target = 32'h1122_3344;
      set_config(target, 32'd0);
      // Match early; a later match in the same record gives nothing more.
      push_sub(target, 32'd3, 3);
      push_sub(target, 32'd1, 1);
      send_record();
      // Match completing on the last byte.
      push_sub(target, 32'd2, 2);
      send_record();
      // A different id first, then the match.
      push_sub(~target, 32'd1, 1);
      push_sub(target, 32'd4, 4);
      send_record();
      // Zero size ends the search.
      push_sub(target, 32'd0, 0);
      push_sub(target, 32'd1, 1);
      send_record();
      // Truncated header.
      push_sub(32'hA5A5_0000, 32'd2, 2);
      push_fill(5);
      send_record();
      // Payload overruns the record, with the largest size and with a small one.
      push_sub(target, ALL_ONES, 3);
      send_record();
      push_sub(target, 32'd5, 3);
      send_record();
      // Single-byte record.
      push_fill(1);
      send_record();
   endtask

   // Extremes of both registers.
   task automatic test_config_extremes();
      set_config(ALL_ONES, ALL_ONES);
      push_fill(6);
      send_record();
      set_config(ALL_ONES, 32'd0);
      push_sub(ALL_ONES, 32'd1, 1);
      push_fill(2);
      send_record();
      set_config(32'd0, 32'd3);
      push_fill(3);
      push_sub(32'h0000_0100, 32'd1, 1);
      push_sub(32'd0, 32'd2, 2);
      push_fill(1);
      send_record();
      settle_block();
   endtask

   // Hold responses off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      set_config(32'h0BAD_F00D, 32'd0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      @(negedge clock);
      repeat (4) begin
         push_sub(cfg_target, 32'd1, 1);
         push_fill(6);
         send_record();
      end
      settle_block();
   endtask

   // Build a random record: mostly a subrecord chain, some plain noise.
   task automatic build_random_record();
      logic [31:0] id;
      logic [31:0] size;
      int          keep;
      if ($urandom_range(9) < 2) begin
         push_fill($urandom_range(1, 24));
      end else begin
         if (cfg_start <= 32)
            push_fill(cfg_start);
         else
            push_fill($urandom_range(1, 8));
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(3))
               0, 1:    id = cfg_target;
               2:       id = $urandom;
               default: id = cfg_target ^ (32'hFF << (8 * $urandom_range(3)));
            endcase
            size = ($urandom_range(19) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
            push_sub(id, size, size);
         end
         case ($urandom_range(9))
            0: begin
               // Cut the record short inside the chain.
               keep = $urandom_range(1, record_bytes.size());
               while (record_bytes.size() > keep)
                  void'(record_bytes.pop_back());
            end
            1: push_sub(cfg_target, 32'($urandom_range(7, 40)), $urandom_range(0, 6));
            default: push_fill($urandom_range(0, 4));
         endcase
      end
   endtask

   // Random records in three idling phases, with settings changed every few records.
   task automatic test_random_records();
      int phase_end;
      int records;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 59 : 0;
         recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 26 : 0;
         phase_end = items_sent + 120;
         records   = 0;
         while (items_sent < phase_end) begin
            if (records % 6 == 0)
               set_config(($urandom_range(3) == 0) ? ALL_ONES : $urandom,
                          ($urandom_range(9) == 0) ? 32'd16 : 32'($urandom_range(0, 6)));
            build_random_record();
            send_record();
            records++;
         end
      end
   endtask

   initial begin
      clear_walk();
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_directed_cases();
      test_config_extremes();
      test_backpressure();
      test_random_records();
      settle_block();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/tsf_pkg.sv
rtl/core/tsf_front.sv
rtl/core/tsf_queue.sv
rtl/core/tsf_walker.sv
rtl/core/tlv_subrecord_finder.sv
test/tb.sv
